// File: sv/scs_pkg.sv
// scs_pkg: shared codes, widths and types for the segment constraint solver.
// No dependencies; imported by every module of the block.
package scs_pkg;

	localparam int LIMIT_W = 52;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

	// action codes: which item may move
	localparam logic [1:0] ACT_END1  = 2'd0;
	localparam logic [1:0] ACT_END2  = 2'd1;
	localparam logic [1:0] ACT_POINT = 2'd2;

	// target codes of a result
	localparam logic [1:0] TGT_NONE  = 2'd0;
	localparam logic [1:0] TGT_END1  = 2'd0;
	localparam logic [1:0] TGT_END2  = 2'd1;
	localparam logic [1:0] TGT_POINT = 2'd2;

	typedef struct packed {
		logic       applied;
		logic [1:0] target;
		logic       proj;
	} ctl_t;

endpackage

// File: sv/scs_front.sv
// scs_front: first four pipeline stages - differences, products, sums of squares
// and dot product, and the choice of result. Depends on scs_pkg.
module scs_front import scs_pkg::*; #(
	parameter int W = 24
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [1:0]           action,
	input  logic signed [W-1:0]  e1 [3],
	input  logic signed [W-1:0]  e2 [3],
	input  logic signed [W-1:0]  pt [3],
	input  logic [LIMIT_W-1:0]   limit,
	output ctl_t                 ctl_s4,
	output logic signed [W-1:0]  alt_s4 [3],
	output logic signed [W-1:0]  e1_s4 [3],
	output logic [W-1:0]         dmag_s4 [3],
	output logic [2:0]           dneg_s4,
	output logic [2*W+1:0]       dot_s4,
	output logic [2*W+1:0]       len2_s4
);

	localparam int SQ_W  = 2*W+2;
	localparam int DOT_W = 2*W+3;
	localparam int CMP_W = (SQ_W > LIMIT_W) ? SQ_W : LIMIT_W;

	// stage 1: vectors from the end named by action (end2 for ACT_END2, else end1)
	logic signed [W-1:0] base_c [3];
	logic signed [W-1:0] other_c [3];
	logic signed [W:0]   a_c [3];
	logic signed [W:0]   b_c [3];

	logic [1:0]          act_s1;
	logic signed [W:0]   a_s1 [3];
	logic signed [W:0]   b_s1 [3];
	logic signed [W-1:0] e1_s1 [3];
	logic signed [W-1:0] e2_s1 [3];
	logic signed [W-1:0] pt_s1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			base_c[i]  = (action == ACT_END2) ? e2[i] : e1[i];
			other_c[i] = (action == ACT_END2) ? e1[i] : e2[i];
			a_c[i] = $signed({other_c[i][W-1], other_c[i]}) - $signed({base_c[i][W-1], base_c[i]});
			b_c[i] = $signed({pt[i][W-1], pt[i]}) - $signed({base_c[i][W-1], base_c[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= action;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= a_c[i];
				b_s1[i]  <= b_c[i];
				e1_s1[i] <= e1[i];
				e2_s1[i] <= e2[i];
				pt_s1[i] <= pt[i];
			end
		end
	end

	// stage 2: per-axis products
	logic signed [2*W+1:0] pa_c [3];
	logic signed [2*W+1:0] pb_c [3];
	logic signed [2*W+1:0] pab_c [3];
	logic [W-1:0]          dmag_c [3];

	logic [1:0]            act_s2;
	logic [2*W-1:0]        sqa_s2 [3];
	logic [2*W-1:0]        sqb_s2 [3];
	logic signed [2*W+1:0] xab_s2 [3];
	logic [W-1:0]          dmag_s2 [3];
	logic [2:0]            dneg_s2;
	logic signed [W-1:0]   e1_s2 [3];
	logic signed [W-1:0]   e2_s2 [3];
	logic signed [W-1:0]   pt_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa_c[i]   = SQ_W'(a_s1[i]) * SQ_W'(a_s1[i]);
			pb_c[i]   = SQ_W'(b_s1[i]) * SQ_W'(b_s1[i]);
			pab_c[i]  = SQ_W'(a_s1[i]) * SQ_W'(b_s1[i]);
			dmag_c[i] = a_s1[i][W] ? W'(-a_s1[i]) : W'(a_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			for (int i = 0; i < 3; i++) begin
				sqa_s2[i]  <= pa_c[i][2*W-1:0];
				sqb_s2[i]  <= pb_c[i][2*W-1:0];
				xab_s2[i]  <= pab_c[i];
				dmag_s2[i] <= dmag_c[i];
				dneg_s2[i] <= a_s1[i][W];
				e1_s2[i]   <= e1_s1[i];
				e2_s2[i]   <= e2_s1[i];
				pt_s2[i]   <= pt_s1[i];
			end
		end
	end

	// stage 3: sums
	logic [SQ_W-1:0]         len2_c;
	logic [SQ_W-1:0]         lb2_c;
	logic signed [DOT_W-1:0] dot_c;

	logic [1:0]              act_s3;
	logic [SQ_W-1:0]         len2_s3;
	logic [SQ_W-1:0]         lb2_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic [W-1:0]            dmag_s3 [3];
	logic [2:0]              dneg_s3;
	logic signed [W-1:0]     e1_s3 [3];
	logic signed [W-1:0]     e2_s3 [3];
	logic signed [W-1:0]     pt_s3 [3];

	always_comb begin
		len2_c = SQ_W'(sqa_s2[0]) + SQ_W'(sqa_s2[1]) + SQ_W'(sqa_s2[2]);
		lb2_c  = SQ_W'(sqb_s2[0]) + SQ_W'(sqb_s2[1]) + SQ_W'(sqb_s2[2]);
		dot_c  = $signed({xab_s2[0][2*W+1], xab_s2[0]})
			+ $signed({xab_s2[1][2*W+1], xab_s2[1]})
			+ $signed({xab_s2[2][2*W+1], xab_s2[2]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3  <= act_s2;
			len2_s3 <= len2_c;
			lb2_s3  <= lb2_c;
			dot_s3  <= dot_c;
			dneg_s3 <= dneg_s2;
			for (int i = 0; i < 3; i++) begin
				dmag_s3[i] <= dmag_s2[i];
				e1_s3[i]   <= e1_s2[i];
				e2_s3[i]   <= e2_s2[i];
				pt_s3[i]   <= pt_s2[i];
			end
		end
	end

	// stage 4: decide what the result is
	logic                lim_hit_c;
	logic                dot_le0_c;
	logic                dot_ge_c;
	logic                far_c;
	ctl_t                ctl_c;
	logic signed [W-1:0] alt_c [3];

	always_comb begin
		lim_hit_c = CMP_W'(len2_s3) < CMP_W'(limit);
		dot_le0_c = dot_s3[DOT_W-1] || (dot_s3 == '0);
		dot_ge_c  = dot_s3 >= $signed({1'b0, len2_s3});
		far_c     = len2_s3 < lb2_s3;
		ctl_c     = '0;
		for (int i = 0; i < 3; i++) alt_c[i] = '0;
		unique case (act_s3)
			ACT_END1, ACT_END2: begin
				if (far_c) begin
					ctl_c.applied = 1'b1;
					ctl_c.target  = act_s3;
					for (int i = 0; i < 3; i++) alt_c[i] = pt_s3[i];
				end
			end
			ACT_POINT: begin
				ctl_c.applied = 1'b1;
				ctl_c.target  = TGT_POINT;
				// degenerate segment collapses onto the second end
				priority if (lim_hit_c) begin
					for (int i = 0; i < 3; i++) alt_c[i] = e2_s3[i];
				end else if (dot_le0_c) begin
					for (int i = 0; i < 3; i++) alt_c[i] = e1_s3[i];
				end else if (dot_ge_c) begin
					for (int i = 0; i < 3; i++) alt_c[i] = e2_s3[i];
				end else begin
					ctl_c.proj = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4  <= ctl_c;
			dneg_s4 <= dneg_s3;
			dot_s4  <= dot_s3[SQ_W-1:0];
			len2_s4 <= len2_s3;
			for (int i = 0; i < 3; i++) begin
				alt_s4[i]  <= alt_c[i];
				e1_s4[i]   <= e1_s3[i];
				dmag_s4[i] <= dmag_s3[i];
			end
		end
	end

endmodule

// File: sv/scs_div.sv
// scs_div: projection offset |d|*dot/len2 rounded to nearest, three lanes; numerator
// product over two stages, restoring division one quotient bit a stage. Depends on scs_pkg.
module scs_div import scs_pkg::*; #(
	parameter int W = 24
) (
	input  logic                 clk,
	input  logic                 en,
	input  ctl_t                 ctl_in,
	input  logic signed [W-1:0]  alt_in [3],
	input  logic signed [W-1:0]  e1_in [3],
	input  logic [W-1:0]         dmag_in [3],
	input  logic [2:0]           dneg_in,
	input  logic [2*W+1:0]       dot_in,
	input  logic [2*W+1:0]       len2_in,
	output ctl_t                 ctl_sr,
	output logic signed [W-1:0]  alt_sr [3],
	output logic signed [W-1:0]  e1_sr [3],
	output logic [2:0]           dneg_sr,
	output logic [W-1:0]         q_sr [3]
);

	localparam int SQ_W  = 2*W+2;
	localparam int NUM_W = 3*W+2;
	localparam int PP_W  = 2*W+1;

	// stage 5: partial products on the two halves of dot
	ctl_t                ctl_s5;
	logic signed [W-1:0] alt_s5 [3];
	logic signed [W-1:0] e1_s5 [3];
	logic [2:0]          dneg_s5;
	logic [SQ_W-1:0]     den_s5;
	logic [2*W:0]        plo_s5 [3];
	logic [2*W:0]        phi_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5  <= ctl_in;
			dneg_s5 <= dneg_in;
			den_s5  <= len2_in;
			for (int i = 0; i < 3; i++) begin
				alt_s5[i] <= alt_in[i];
				e1_s5[i]  <= e1_in[i];
				plo_s5[i] <= PP_W'(dmag_in[i]) * PP_W'(dot_in[W:0]);
				phi_s5[i] <= PP_W'(dmag_in[i]) * PP_W'(dot_in[2*W+1:W+1]);
			end
		end
	end

	// divider chain: index 0 holds the numerator, index k the state after k steps
	ctl_t                ctl_sd  [W+1];
	logic signed [W-1:0] alt_sd  [W+1][3];
	logic signed [W-1:0] e1_sd   [W+1][3];
	logic [2:0]          dneg_sd [W+1];
	logic [SQ_W-1:0]     den_sd  [W+1];
	logic [NUM_W-1:0]    rem_sd  [W+1][3];
	logic [W-1:0]        q_sd    [W+1][3];

	// stage 6: numerator
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sd[0]  <= ctl_s5;
			dneg_sd[0] <= dneg_s5;
			den_sd[0]  <= den_s5;
			for (int i = 0; i < 3; i++) begin
				alt_sd[0][i] <= alt_s5[i];
				e1_sd[0][i]  <= e1_s5[i];
				rem_sd[0][i] <= NUM_W'(plo_s5[i]) + (NUM_W'(phi_s5[i]) << (W+1));
				q_sd[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_step
		localparam int BIT = W-1-j;
		logic [NUM_W:0] trial [3];

		always_comb begin
			for (int i = 0; i < 3; i++)
				trial[i] = {1'b0, rem_sd[j][i]} - {1'b0, NUM_W'(den_sd[j]) << BIT};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sd[j+1]  <= ctl_sd[j];
				dneg_sd[j+1] <= dneg_sd[j];
				den_sd[j+1]  <= den_sd[j];
				for (int i = 0; i < 3; i++) begin
					alt_sd[j+1][i] <= alt_sd[j][i];
					e1_sd[j+1][i]  <= e1_sd[j][i];
					if (!trial[i][NUM_W]) begin
						rem_sd[j+1][i] <= trial[i][NUM_W-1:0];
						q_sd[j+1][i]   <= q_sd[j][i] | (W'(1) << BIT);
					end else begin
						rem_sd[j+1][i] <= rem_sd[j][i];
						q_sd[j+1][i]   <= q_sd[j][i];
					end
				end
			end
		end
	end

	// round stage: remainder is below len2, so twice it fits one more bit
	logic rnd_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			rnd_c[i] = {rem_sd[W][i][SQ_W-1:0], 1'b0} >= {1'b0, den_sd[W]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sr  <= ctl_sd[W];
			dneg_sr <= dneg_sd[W];
			for (int i = 0; i < 3; i++) begin
				alt_sr[i] <= alt_sd[W][i];
				e1_sr[i]  <= e1_sd[W][i];
				q_sr[i]   <= q_sd[W][i] + W'(rnd_c[i]);
			end
		end
	end

endmodule

// File: sv/segment_constraint_solver.sv
// segment_constraint_solver: top level - handshakes, limit register, final sum and
// output register with skid stage. Depends on scs_pkg, scs_front and scs_div.

// Moves one of a 3D segment's endpoints or a point onto/along the segment, coordinates
// signed fixed point (Q12.12 at the default width). One item is taken every clock while
// the skid stage is empty. The depth is set by the projection divider, which resolves
// one quotient bit per stage in each of three lanes, plus four front stages of
// differences, products, sums and the choice of result, two stages that form the
// numerator, a rounding stage and the output register. The output register is backed
// by a skid stage, so input transfers continue after the output stalls until a result
// fills it; the pipeline holds only while the skid stage is full. degenerate_limit
// (held in limit_q; squared length, same scale as a squared coordinate) resets to 1; it
// must be written by cfg_we/cfg_wdata only while no item is in flight, and the block
// itself does not enforce this.
module segment_constraint_solver import scs_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [LIMIT_W-1:0]            cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] end1_x,
	input  logic signed [COORD_WIDTH-1:0] end1_y,
	input  logic signed [COORD_WIDTH-1:0] end1_z,
	input  logic signed [COORD_WIDTH-1:0] end2_x,
	input  logic signed [COORD_WIDTH-1:0] end2_y,
	input  logic signed [COORD_WIDTH-1:0] end2_z,
	input  logic signed [COORD_WIDTH-1:0] pt_x,
	input  logic signed [COORD_WIDTH-1:0] pt_y,
	input  logic signed [COORD_WIDTH-1:0] pt_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          applied,
	output logic [1:0]                    target,
	output logic signed [COORD_WIDTH-1:0] new_x,
	output logic signed [COORD_WIDTH-1:0] new_y,
	output logic signed [COORD_WIDTH-1:0] new_z
);

	localparam int W    = COORD_WIDTH;
	localparam int PSTG = W + 7;

	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	logic            en;
	logic [PSTG-1:0] v_q;
	logic            skid_q;
	logic            out_valid_q;

	assign en       = !skid_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PSTG-2:0], in_valid};
		end
	end

	logic signed [W-1:0] e1_a [3];
	logic signed [W-1:0] e2_a [3];
	logic signed [W-1:0] pt_a [3];

	assign e1_a[0] = end1_x;
	assign e1_a[1] = end1_y;
	assign e1_a[2] = end1_z;
	assign e2_a[0] = end2_x;
	assign e2_a[1] = end2_y;
	assign e2_a[2] = end2_z;
	assign pt_a[0] = pt_x;
	assign pt_a[1] = pt_y;
	assign pt_a[2] = pt_z;

	ctl_t                ctl_s4;
	logic signed [W-1:0] alt_s4 [3];
	logic signed [W-1:0] e1_s4 [3];
	logic [W-1:0]        dmag_s4 [3];
	logic [2:0]          dneg_s4;
	logic [2*W+1:0]      dot_s4;
	logic [2*W+1:0]      len2_s4;

	scs_front #(
		.W(W)
	) u_front (
		.clk     (clk),
		.en      (en),
		.action  (action),
		.e1      (e1_a),
		.e2      (e2_a),
		.pt      (pt_a),
		.limit   (limit_q),
		.ctl_s4  (ctl_s4),
		.alt_s4  (alt_s4),
		.e1_s4   (e1_s4),
		.dmag_s4 (dmag_s4),
		.dneg_s4 (dneg_s4),
		.dot_s4  (dot_s4),
		.len2_s4 (len2_s4)
	);

	ctl_t                ctl_sr;
	logic signed [W-1:0] alt_sr [3];
	logic signed [W-1:0] e1_sr [3];
	logic [2:0]          dneg_sr;
	logic [W-1:0]        q_sr [3];

	scs_div #(
		.W(W)
	) u_div (
		.clk     (clk),
		.en      (en),
		.ctl_in  (ctl_s4),
		.alt_in  (alt_s4),
		.e1_in   (e1_s4),
		.dmag_in (dmag_s4),
		.dneg_in (dneg_s4),
		.dot_in  (dot_s4),
		.len2_in (len2_s4),
		.ctl_sr  (ctl_sr),
		.alt_sr  (alt_sr),
		.e1_sr   (e1_sr),
		.dneg_sr (dneg_sr),
		.q_sr    (q_sr)
	);

	// final position: projected offset applied to end1, or the chosen copy
	logic signed [W-1:0] res_c [3];
	logic                push;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_sr.proj) begin
				res_c[i] = dneg_sr[i] ? e1_sr[i] - $signed(q_sr[i]) : e1_sr[i] + $signed(q_sr[i]);
			end else begin
				res_c[i] = alt_sr[i];
			end
		end
	end

	assign push = en && v_q[PSTG-1];

	logic                out_applied_q;
	logic [1:0]          out_target_q;
	logic signed [W-1:0] out_new_q [3];
	logic                skid_applied_q;
	logic [1:0]          skid_target_q;
	logic signed [W-1:0] skid_new_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= skid_q || push;
			skid_q      <= 1'b0;
		end else if (push) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_q) begin
				out_applied_q <= skid_applied_q;
				out_target_q  <= skid_target_q;
				for (int i = 0; i < 3; i++) out_new_q[i] <= skid_new_q[i];
			end else begin
				out_applied_q <= ctl_sr.applied;
				out_target_q  <= ctl_sr.target;
				for (int i = 0; i < 3; i++) out_new_q[i] <= res_c[i];
			end
		end else if (push) begin
			skid_applied_q <= ctl_sr.applied;
			skid_target_q  <= ctl_sr.target;
			for (int i = 0; i < 3; i++) skid_new_q[i] <= res_c[i];
		end
	end

	assign out_valid = out_valid_q;
	assign applied   = out_applied_q;
	assign target    = out_target_q;
	assign new_x     = out_new_q[0];
	assign new_y     = out_new_q[1];
	assign new_z     = out_new_q[2];

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && push |=> skid_q)
		else $error("result from the pipeline dropped while the output stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !applied |-> target == TGT_NONE && new_x == '0 && new_y == '0 && new_z == '0)
		else $error("result not applied but fields are non-zero");

	a_point_applied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && target == TGT_POINT |-> applied)
		else $error("point target without applied flag");

endmodule
